/* rtl/swst_pkg.sv */
// swst_pkg: shared widths, operation and status codes and control types
// for the sequence window slot table; depends on nothing
package swst_pkg;

  localparam int FUNC_W     = 2;
  localparam int SEQ_W      = 32;
  localparam int HANDLE_W   = 32;
  localparam int LEN_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 7;
  localparam int ENTRY_W    = SEQ_W + HANDLE_W + LEN_W;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 56;
  localparam int DIV_STEPS  = SEQ_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int DEF_MAX_WINDOW = 64;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input word, start the modulo
    logic step;    // one restoring modulo step
    logic commit;  // update the table and load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a word this cycle
  } stat_t;

endpackage

/* rtl/sequence_window_slot_table.sv */
// sequence_window_slot_table: top level, joins the controller and the
// datapath; uses swst_pkg, swst_ctrl, swst_dp (and swst_ram below it)
//
// Slot table for a sliding packet window. Each input word carries an
// operation in in_tuser (insert, get, remove, clear) and a sequence number,
// buffer handle and length in in_tdata. The slot of a sequence number is
// seq_num modulo the effective window (cfg_data, 0 taken as 1, above
// MAX_WINDOW taken as MAX_WINDOW). Insert reports table full before slot
// occupied; get and remove hit only on a valid slot holding the same
// sequence number, else not found. Clear drops every valid flag, including
// slots beyond a smaller window. Every result word carries table full and
// table empty after the operation. Each word goes through accept, the
// bit-serial restoring modulo (one sequence bit per cycle), the registered
// slot ram read and a commit that updates the table and loads the result
// register, before the next word is accepted. The result word is loaded at
// commit and waits in its own register, so a new word is accepted while it
// waits; commit holds only while the previous result is still untaken.
// Window writes are taken at any time but are meant for an idle block.
// Slot contents have no reset and are only read under a valid flag; the
// valid flags reset to zero at once.
module sequence_window_slot_table #(
  parameter int MAX_WINDOW = swst_pkg::DEF_MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: window_size
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swst_pkg::CFG_W-1:0]      cfg_data,
  // input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // seq_num [31:0], buffer_handle [63:32], packet_length [79:64]
  input  logic [swst_pkg::IN_DATA_W-1:0]  in_tdata,
  // func [1:0], zero fill [7:2]
  input  logic [swst_pkg::IN_USER_W-1:0]  in_tuser,
  // result words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status [1:0], found_handle [33:2], found_length [49:34],
  // table_full [50], table_empty [51], zero fill [55:52]
  output logic [swst_pkg::OUT_DATA_W-1:0] out_tdata
);

  swst_pkg::cmd_t  cmd;
  swst_pkg::stat_t stat;

  // window register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: accept, modulo steps, ram read, commit
  swst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // window register, modulo unit, slot table and result register
  swst_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/swst_ram.sv */
// swst_ram: generic single write port, single read port ram with
// registered read data; depends on nothing
module swst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/swst_ctrl.sv */
// swst_ctrl: sequencer for one operation: accept, modulo steps, slot read,
// commit; uses swst_pkg
module swst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  swst_pkg::stat_t stat,
  output swst_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [swst_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == swst_pkg::STEP_W'(swst_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // slot address settles, ram read data lands next cycle
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r == '0)
    else $error("step counter not cleared in idle");

  a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_DIV && cnt_r == '0)
    else $error("accept did not start the modulo");

endmodule

/* rtl/swst_dp.sv */
// swst_dp: window register, restoring modulo unit, valid flags, count,
// slot ram and result register; uses swst_pkg and swst_ram
module swst_dp #(
  parameter int MAX_WINDOW = swst_pkg::DEF_MAX_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swst_pkg::cmd_t                    cmd,
  output swst_pkg::stat_t                   stat,
  input  logic                              cfg_valid,
  input  logic [swst_pkg::CFG_W-1:0]        cfg_data,
  input  logic [swst_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [swst_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swst_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CW     = swst_pkg::CFG_W;

  // configuration and effective window
  logic [CW-1:0] win_size_r;
  logic [CW-1:0] win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= swst_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      win_size_r <= cfg_data;
    end
  end

  always_comb begin
    if (win_size_r == '0) begin
      win = CW'(1);
    end else if (32'(win_size_r) > 32'(MAX_WINDOW)) begin
      win = CW'(MAX_WINDOW);
    end else begin
      win = win_size_r;
    end
  end

  // captured input word
  logic [swst_pkg::FUNC_W-1:0]   func_r;
  logic [swst_pkg::SEQ_W-1:0]    seq_r;
  logic [swst_pkg::SEQ_W-1:0]    quot_r;
  logic [swst_pkg::HANDLE_W-1:0] handle_r;
  logic [swst_pkg::LEN_W-1:0]    len_r;
  logic [CW-1:0]                 rem_r;
  logic [CW:0]                   rem_ext;
  logic [CW-1:0]                 rem_nxt;

  // restoring modulo, one dividend bit per step
  always_comb begin
    rem_ext = {rem_r, quot_r[swst_pkg::SEQ_W-1]};
    if (rem_ext >= {1'b0, win}) begin
      rem_nxt = CW'(rem_ext - {1'b0, win});
    end else begin
      rem_nxt = CW'(rem_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_tuser[swst_pkg::FUNC_W-1:0];
      seq_r    <= in_tdata[31:0];
      quot_r   <= in_tdata[31:0];
      handle_r <= in_tdata[63:32];
      len_r    <= in_tdata[79:64];
      rem_r    <= '0;
    end else if (cmd.step) begin
      quot_r <= {quot_r[swst_pkg::SEQ_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
    end
  end

  logic [SLOT_W-1:0] slot;
  assign slot = SLOT_W'(rem_r);

  // slot ram: {length, handle, sequence}
  logic                          ram_we;
  logic [swst_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [swst_pkg::SEQ_W-1:0]    rd_seq;
  logic [swst_pkg::HANDLE_W-1:0] rd_handle;
  logic [swst_pkg::LEN_W-1:0]    rd_len;

  swst_ram #(
    .WIDTH (swst_pkg::ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({len_r, handle_r, seq_r}),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign rd_seq    = ram_rdata[31:0];
  assign rd_handle = ram_rdata[63:32];
  assign rd_len    = ram_rdata[79:64];

  // table state and result
  logic [MAX_WINDOW-1:0]         valid_r, valid_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r;
  logic [swst_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [swst_pkg::HANDLE_W-1:0] fhandle_r, fhandle_nxt;
  logic [swst_pkg::LEN_W-1:0]    flen_r, flen_nxt;
  logic                          full_r, empty_r;
  logic                          slot_vld, match;

  assign stat.out_free = !out_valid_r || out_tready;

  assign slot_vld = valid_r[slot];
  assign match    = slot_vld && (rd_seq == seq_r);

  always_comb begin
    valid_nxt   = valid_r;
    cnt_nxt     = cnt_r;
    status_nxt  = swst_pkg::ST_OK;
    fhandle_nxt = '0;
    flen_nxt    = '0;
    ram_we      = 1'b0;
    case (func_r)
      swst_pkg::OP_INSERT: begin
        if (32'(cnt_r) >= 32'(win)) begin
          status_nxt = swst_pkg::ST_FULL;
        end else if (slot_vld) begin
          status_nxt = swst_pkg::ST_OCCUPIED;
        end else begin
          valid_nxt[slot] = 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
          ram_we          = cmd.commit;
        end
      end
      swst_pkg::OP_GET: begin
        if (match) begin
          fhandle_nxt = rd_handle;
          flen_nxt    = rd_len;
        end else begin
          status_nxt = swst_pkg::ST_NOT_FOUND;
        end
      end
      swst_pkg::OP_REMOVE: begin
        if (match) begin
          valid_nxt[slot] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end else begin
          status_nxt = swst_pkg::ST_NOT_FOUND;
        end
      end
      swst_pkg::OP_CLEAR: begin
        valid_nxt = '0;
        cnt_nxt   = '0;
      end
      default: begin
        status_nxt = swst_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        valid_r     <= valid_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      fhandle_r <= fhandle_nxt;
      flen_r    <= flen_nxt;
      full_r    <= (32'(cnt_nxt) >= 32'(win));
      empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, empty_r, full_r, flen_r, fhandle_r, status_r};

  a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("valid count disagrees with valid flags");

  a_rem_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step) |-> rem_r < win)
    else $error("modulo remainder not below window");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result word appeared without a commit");

endmodule
